>>> rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared constants and types of the Cartesian to spherical unit
// Angle constants on the internal Q30 radian scale, the arctangent table
// and the flag group that travels down the pipeline beside each word.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int TableLen = 30;

  // pi, pi/2 and 2pi in Q30 radians
  localparam logic [32:0] ANG_PI      = 33'd3373259426;
  localparam logic [32:0] ANG_HALF_PI = 33'd1686629713;
  localparam logic [32:0] ANG_TWO_PI  = 33'd6746518852;

  // 180/pi in Q24
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  // output saturation limits
  localparam logic [24:0] AZ_MAX  = 25'h1FFFFFF;
  localparam logic [23:0] EL_MAX  = 24'hFFFFFF;
  localparam logic [31:0] RAD_MAX = 32'hFFFFFFFF;

  // atan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_Q30 [TableLen] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  // per-word flags carried along the pipeline
  typedef struct packed {
    logic sx;        // x negative
    logic sy;        // y negative
    logic sz;        // z negative
    logic plane_nz;  // x*x + y*y nonzero
    logic zero;      // whole vector zero
  } flags_t;

endpackage

>>> rtl/c2s_sqrt.sv
// ----------------------------------------------------------------------------
// c2s_sqrt: pipelined rounded square root of a 64-bit value
// One result bit per stage over 32 stages, then a rounding stage that adds
// one when the remainder exceeds the floor root. A sideband rides along.
// ----------------------------------------------------------------------------
module c2s_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [32:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int Steps = 32;

  logic [63:0]       rem_q  [Steps];
  logic [63:0]       res_q  [Steps];
  logic              vld_q  [Steps];
  logic [SIDE_W-1:0] side_q [Steps];

  logic [32:0]       root_q;
  logic              vout_q;
  logic [SIDE_W-1:0] sout_q;

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    logic [63:0]       rem_in;
    logic [63:0]       res_in;
    logic [63:0]       trial;
    logic              v_in;
    logic [SIDE_W-1:0] s_in;

    if (j == 0) begin : g_first
      assign rem_in = n_i;
      assign res_in = '0;
      assign v_in   = valid_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign v_in   = vld_q[j-1];
      assign s_in   = side_q[j-1];
    end

    assign trial = res_in + Bit;

    // advance valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    // one restoring step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= s_in;
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          res_q[j] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= vld_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sout_q <= side_q[Steps-1];
      root_q <= {1'b0, res_q[Steps-1][31:0]}
              + {32'd0, (rem_q[Steps-1] > res_q[Steps-1])};
    end
  end

  assign valid_o = vout_q;
  assign root_o  = root_q;
  assign side_o  = sout_q;

endmodule

>>> rtl/c2s_cordic.sv
// ----------------------------------------------------------------------------
// c2s_cordic: pipelined vectoring CORDIC giving atan(b / a) in Q30
// Two normalizing stages lift the larger operand to at least 2^30, then one
// stage per rotation, then a clamp to 0..pi/2. A sideband rides along.
// ----------------------------------------------------------------------------
module c2s_cordic #(
  parameter int STEPS  = 20,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [32:0]       a_i,
  input  logic [32:0]       b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       ang_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [32:0] big;
  logic [4:0]  shift_d;
  logic [4:0]  shift_q;
  logic [32:0] a_q, b_q;
  logic        v1_q, v2_q, vout_q;
  logic [SIDE_W-1:0] s1_q, s2_q, sout_q;
  logic signed [35:0] cx0_q, cy0_q;
  logic [30:0] ang_q;

  logic signed [35:0] cx_q   [STEPS];
  logic signed [35:0] cy_q   [STEPS];
  logic signed [32:0] acc_q  [STEPS];
  logic               vld_q  [STEPS];
  logic [SIDE_W-1:0]  side_q [STEPS];

  // find the left shift that lifts the larger operand to 2^30
  assign big = (a_i > b_i) ? a_i : b_i;

  always_comb begin
    shift_d = '0;
    if (big[32:30] == 3'd0) begin
      for (int i = 0; i < 30; i++) begin
        if (big[i]) begin
          shift_d = 5'(30 - i);
        end
      end
    end
  end

  // valid bits of the normalizing stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_i;
      b_q     <= b_i;
      shift_q <= shift_d;
      s1_q    <= side_i;
      cx0_q   <= $signed({3'd0, 33'(a_q << shift_q)});
      cy0_q   <= $signed({3'd0, 33'(b_q << shift_q)});
      s2_q    <= s1_q;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_rot
    localparam logic signed [32:0] Atan = $signed({1'b0, c2s_pkg::ATAN_Q30[j]});
    logic signed [35:0] cx_in, cy_in, dx, dy;
    logic signed [32:0] acc_in;
    logic               v_in;
    logic [SIDE_W-1:0]  s_in;

    if (j == 0) begin : g_first
      assign cx_in  = cx0_q;
      assign cy_in  = cy0_q;
      assign acc_in = '0;
      assign v_in   = v2_q;
      assign s_in   = s2_q;
    end else begin : g_next
      assign cx_in  = cx_q[j-1];
      assign cy_in  = cy_q[j-1];
      assign acc_in = acc_q[j-1];
      assign v_in   = vld_q[j-1];
      assign s_in   = side_q[j-1];
    end

    assign dx = cy_in >>> j;
    assign dy = cx_in >>> j;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= s_in;
        if (cy_in > 0) begin
          cx_q[j]  <= cx_in + dx;
          cy_q[j]  <= cy_in - dy;
          acc_q[j] <= acc_in + Atan;
        end else begin
          cx_q[j]  <= cx_in - dx;
          cy_q[j]  <= cy_in + dy;
          acc_q[j] <= acc_in - Atan;
        end
      end
    end
  end

  // clamp to 0..pi/2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= vld_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sout_q <= side_q[STEPS-1];
      if (acc_q[STEPS-1] < 0) begin
        ang_q <= '0;
      end else if (acc_q[STEPS-1] > $signed(c2s_pkg::ANG_HALF_PI)) begin
        ang_q <= 31'(c2s_pkg::ANG_HALF_PI);
      end else begin
        ang_q <= acc_q[STEPS-1][30:0];
      end
    end
  end

  assign valid_o = vout_q;
  assign ang_o   = ang_q;
  assign side_o  = sout_q;

endmodule

>>> rtl/cartesian_to_spherical_unit.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unit: streaming Cartesian to spherical converter
// Turns a signed fixed-point vector into radius, elevation and azimuth.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vector per word: x, y, z, signed 32-bit fixed point.
//   m_axis carries one result per word: azimuth, elevation, radius.
//   cfg carries the degree_mode bit (1 = degrees, 0 = radians); it is always
//   ready. The user must write it only while no word is in flight; the
//   block itself does not enforce this.
// Pipeline: five front stages (magnitude, squares, sums, shift search,
//   shift), the 33-stage square root, the CORDIC (3 + CORDIC_STEPS stages)
//   and three output stages lie between an input word and its result.
// Throughput: one word per cycle while the pipeline is not stalled.
// Stall: the whole pipeline holds while the result register is full and
//   m_axis_tready is low; s_axis_tready drops for those cycles only.
// Reset: all valid bits clear and degree_mode returns to radians.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // vec_x[31:0], vec_y[63:32], vec_z[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // azimuth[24:0], elevation[48:25],
                                      // radius[80:49], zero fill[87:81]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int DegShift = 54 - FRAC_BITS;
  localparam int RadShift = 30 - FRAC_BITS;
  localparam logic [63:0] DegHalf = 64'd1 << (DegShift - 1);
  localparam logic [63:0] RadHalf = 64'd1 << (RadShift - 1);
  localparam int SideA = 64 + $bits(c2s_pkg::flags_t);
  localparam int SideC = 33 + $bits(c2s_pkg::flags_t);

  logic en;
  logic deg_q;

  // front stages
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [31:0] ax1_q, ay1_q, az1_q;
  c2s_pkg::flags_t f1_q, f2_q, f3_q, f4_q, f5_q;
  logic [31:0] ax2_q, ay2_q, az2_q;
  logic [63:0] px2_q, py2_q, pz2_q;
  logic [31:0] ax3_q, ay3_q, az3_q;
  logic [63:0] plane3_q, zsq3_q, total3_q;
  logic [31:0] ax4_q, ay4_q, az4_q;
  logic [63:0] plane4_q, total4_q;
  logic [4:0]  k_d, k4_q;
  logic [63:0] m3;
  logic [31:0] ax5_q, ay5_q, azk5_q;
  logic [63:0] plane5_q, total5_q;
  c2s_pkg::flags_t f3_d;

  // square root outputs
  logic              va_s, vb_s;
  logic [32:0]       root_a, root_b;
  logic [SideA-1:0]  side_a;
  logic [31:0]       side_b;
  logic [31:0]       ax_s, ay_s;
  c2s_pkg::flags_t   f_s;

  // CORDIC outputs
  logic              vaz_c, vel_c;
  logic [30:0]       ang_az, ang_el;
  logic [SideC-1:0]  side_c;
  logic              side_e;
  logic [32:0]       rad_c;
  c2s_pkg::flags_t   f_c;

  // output stages
  logic        vq_q, vm_q, vr_q;
  logic [32:0] azq_q;
  logic [31:0] elq_q;
  logic [31:0] radq_q, radm_q, radr_q;
  logic        zq_q, zm_q;
  logic [32:0] az_fold;
  logic [63:0] azm_q, elm_q;
  logic [63:0] az_rnd, el_rnd;
  logic [24:0] azr_q;
  logic [23:0] elr_q;

  assign en            = !vr_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // hold the angle unit selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 1'b0;
    end else if (cfg_valid_i) begin
      deg_q <= cfg_data_i;
    end
  end

  // advance front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // magnitudes, squares and sums
  always_comb begin
    f3_d          = f2_q;
    f3_d.plane_nz = (px2_q + py2_q) != 64'd0;
    f3_d.zero     = (px2_q + py2_q + pz2_q) == 64'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q   <= s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0])  : s_axis_tdata[31:0];
      ay1_q   <= s_axis_tdata[63] ? 32'(-s_axis_tdata[63:32]) : s_axis_tdata[63:32];
      az1_q   <= s_axis_tdata[95] ? 32'(-s_axis_tdata[95:64]) : s_axis_tdata[95:64];
      f1_q    <= '{sx: s_axis_tdata[31], sy: s_axis_tdata[63], sz: s_axis_tdata[95],
                   plane_nz: 1'b0, zero: 1'b0};
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      az2_q   <= az1_q;
      px2_q   <= 64'(ax1_q) * 64'(ax1_q);
      py2_q   <= 64'(ay1_q) * 64'(ay1_q);
      pz2_q   <= 64'(az1_q) * 64'(az1_q);
      f2_q    <= f1_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      az3_q   <= az2_q;
      plane3_q <= px2_q + py2_q;
      zsq3_q  <= pz2_q;
      total3_q <= px2_q + py2_q + pz2_q;
      f3_q    <= f3_d;
    end
  end

  // search the scale that lifts the larger square to at least 2^60
  assign m3 = (plane3_q > zsq3_q) ? plane3_q : zsq3_q;

  always_comb begin
    k_d = 5'd30;
    for (int i = 0; i < 64; i++) begin
      if (m3[i]) begin
        k_d = (i >= 60) ? 5'd0 : 5'((61 - i) >> 1);
      end
    end
  end

  // scale plane square and z
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
      az4_q    <= az3_q;
      plane4_q <= plane3_q;
      total4_q <= total3_q;
      k4_q     <= k_d;
      f4_q     <= f3_q;
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;
      azk5_q   <= 32'(az4_q << k4_q);
      plane5_q <= plane4_q << {k4_q, 1'b0};
      total5_q <= total4_q;
      f5_q     <= f4_q;
    end
  end

  c2s_sqrt #(.SIDE_W(SideA)) u_sqrt_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .n_i     (total5_q),
    .side_i  ({ax5_q, ay5_q, f5_q}),
    .valid_o (va_s),
    .root_o  (root_a),
    .side_o  (side_a)
  );

  c2s_sqrt #(.SIDE_W(32)) u_sqrt_plane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .n_i     (plane5_q),
    .side_i  (azk5_q),
    .valid_o (vb_s),
    .root_o  (root_b),
    .side_o  (side_b)
  );

  assign {ax_s, ay_s, f_s} = side_a;

  c2s_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(SideC)) u_cordic_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_s),
    .a_i     ({1'b0, ax_s}),
    .b_i     ({1'b0, ay_s}),
    .side_i  ({root_a, f_s}),
    .valid_o (vaz_c),
    .ang_o   (ang_az),
    .side_o  (side_c)
  );

  c2s_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(1)) u_cordic_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_s),
    .a_i     ({1'b0, side_b}),
    .b_i     (root_b),
    .side_i  (f_s.sz),
    .valid_o (vel_c),
    .ang_o   (ang_el),
    .side_o  (side_e)
  );

  assign {rad_c, f_c} = side_c;

  // fold angles into their quadrants
  always_comb begin
    az_fold = f_c.sx ? (c2s_pkg::ANG_PI - {2'b0, ang_az}) : {2'b0, ang_az};
    if (f_c.sy) begin
      az_fold = c2s_pkg::ANG_TWO_PI - az_fold;
    end
    if (!f_c.plane_nz) begin
      az_fold = '0;
    end
  end

  // scale and round to the output format
  assign az_rnd = deg_q ? ((azm_q + DegHalf) >> DegShift) : ((azm_q + RadHalf) >> RadShift);
  assign el_rnd = deg_q ? ((elm_q + DegHalf) >> DegShift) : ((elm_q + RadHalf) >> RadShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
      vm_q <= 1'b0;
      vr_q <= 1'b0;
    end else if (en) begin
      vq_q <= vaz_c;
      vm_q <= vq_q;
      vr_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      azq_q  <= az_fold;
      elq_q  <= side_e ? 32'(c2s_pkg::ANG_PI - {2'b0, ang_el}) : {1'b0, ang_el};
      radq_q <= rad_c[32] ? c2s_pkg::RAD_MAX : rad_c[31:0];
      zq_q   <= f_c.zero;
      if (deg_q) begin
        azm_q <= 64'(azq_q) * 64'(c2s_pkg::DEG_PER_RAD_Q24);
        elm_q <= 64'(elq_q) * 64'(c2s_pkg::DEG_PER_RAD_Q24);
      end else begin
        azm_q <= 64'(azq_q);
        elm_q <= 64'(elq_q);
      end
      radm_q <= radq_q;
      zm_q   <= zq_q;
      if (zm_q) begin
        azr_q  <= '0;
        elr_q  <= '0;
        radr_q <= '0;
      end else begin
        azr_q  <= (az_rnd > 64'(c2s_pkg::AZ_MAX)) ? c2s_pkg::AZ_MAX : az_rnd[24:0];
        elr_q  <= (el_rnd > 64'(c2s_pkg::EL_MAX)) ? c2s_pkg::EL_MAX : el_rnd[23:0];
        radr_q <= radm_q;
      end
    end
  end

  assign m_axis_tvalid = vr_q;
  assign m_axis_tdata  = {7'd0, radr_q, elr_q, azr_q};

  // the two CORDIC lanes stay in step
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vaz_c == vel_c)
    else $error("CORDIC lanes out of step");

  // input stalls only while a finished result waits
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  // pipeline holds while stalled
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v5_q) && $stable(vq_q))
    else $error("pipeline moved during stall");

  // zero radius only for the zero vector, whose angles are zero
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (radr_q == 32'd0) |-> (azr_q == 25'd0) && (elr_q == 24'd0))
    else $error("zero radius with nonzero angle");

endmodule
